// ===== hdl/rcke_pkg.sv =====
// ----------------------------------------------------------------------------
// rcke_pkg
// Shared types, constants and functions of the rolling canonical k-mer encoder.
// ----------------------------------------------------------------------------
package rcke_pkg;

   localparam int MAX_WINDOW = 21;
   localparam int WORD_W     = 64;
   localparam int CODE_W     = 3;
   localparam int FILL_W     = 5;
   localparam int FIELDS     = MAX_WINDOW + 1;
   localparam int SYMBOL_W   = 8;
   localparam int RSP_DATA_W = 136;

   localparam logic [FILL_W-1:0] K_RESET = 5'd15;
   localparam logic [FILL_W-1:0] K_MIN   = 5'd1;
   localparam logic [FILL_W-1:0] K_MAX   = FILL_W'(MAX_WINDOW);

   localparam logic [CODE_W-1:0] CODE_N    = 3'd0;
   localparam logic [CODE_W-1:0] CODE_A    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_C    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_G    = 3'd3;
   localparam logic [CODE_W-1:0] CODE_T    = 3'd4;
   localparam logic [CODE_W-1:0] CODE_TERM = 3'd5;

   localparam logic [SYMBOL_W-1:0] CHAR_UA     = 8'h41;
   localparam logic [SYMBOL_W-1:0] CHAR_UC     = 8'h43;
   localparam logic [SYMBOL_W-1:0] CHAR_UG     = 8'h47;
   localparam logic [SYMBOL_W-1:0] CHAR_UT     = 8'h54;
   localparam logic [SYMBOL_W-1:0] CHAR_LA     = 8'h61;
   localparam logic [SYMBOL_W-1:0] CHAR_LC     = 8'h63;
   localparam logic [SYMBOL_W-1:0] CHAR_LG     = 8'h67;
   localparam logic [SYMBOL_W-1:0] CHAR_LT     = 8'h74;
   localparam logic [SYMBOL_W-1:0] CHAR_DOLLAR = 8'h24;

   typedef struct packed {
      logic              restart;
      logic [CODE_W-1:0] rcode;
      logic [CODE_W-1:0] fcode;
   } item_type;

   function automatic logic [CODE_W-1:0] base_code(input logic [SYMBOL_W-1:0] s);
      logic [CODE_W-1:0] c;
      case (s)
         CHAR_UA, CHAR_LA: c = CODE_A;
         CHAR_UC, CHAR_LC: c = CODE_C;
         CHAR_UG, CHAR_LG: c = CODE_G;
         CHAR_UT, CHAR_LT: c = CODE_T;
         CHAR_DOLLAR:      c = CODE_TERM;
         default:          c = CODE_N;
      endcase
      return c;
   endfunction

   function automatic logic [CODE_W-1:0] comp_code(input logic [CODE_W-1:0] f);
      logic [CODE_W-1:0] c;
      case (f)
         CODE_A:    c = CODE_T;
         CODE_C:    c = CODE_G;
         CODE_G:    c = CODE_C;
         CODE_T:    c = CODE_A;
         CODE_TERM: c = CODE_TERM;
         default:   c = CODE_N;
      endcase
      return c;
   endfunction

   function automatic logic [FILL_W-1:0] eff_k(input logic [FILL_W-1:0] wl);
      logic [FILL_W-1:0] k;
      k = wl;
      if (wl < K_MIN) k = K_MIN;
      if (wl > K_MAX) k = K_MAX;
      return k;
   endfunction

   // Field at pos occupies bits 3*pos+2..3*pos; the top field keeps only bit 63.
   function automatic logic [WORD_W-1:0] put_field(input logic [WORD_W-1:0] w,
                                                    input logic [FILL_W-1:0] pos,
                                                    input logic [CODE_W-1:0] code);
      logic [6:0]        sh;
      logic [WORD_W-1:0] m;
      sh = 7'(pos) * 7'd3;
      m  = WORD_W'(3'b111) << sh;
      return (w & ~m) | ((WORD_W'(code)) << sh);
   endfunction

   function automatic logic is_repetitive(input logic [WORD_W-1:0] w,
                                          input logic [FILL_W-1:0] k);
      logic [CODE_W-1:0] c [FIELDS];
      logic              alive;
      logic              seen1;
      logic              seen2;
      for (int i = 0; i < FIELDS; i++) begin
         c[i] = CODE_W'(w >> (i * CODE_W));
      end
      alive = (c[0] != CODE_TERM);
      seen1 = 1'b0;
      seen2 = 1'b0;
      for (int i = 1; i < FIELDS; i++) begin
         if (alive && (FILL_W'(i) <= k) && (c[i] == c[i-1])) begin
            seen2 = seen2 | seen1;
            seen1 = 1'b1;
         end
         alive = alive && (c[i] != CODE_TERM);
      end
      return seen2;
   endfunction

endpackage

// ===== hdl/rolling_canonical_kmer_encoder.sv =====
// ----------------------------------------------------------------------------
// rolling_canonical_kmer_encoder
// Streams DNA characters into a rolling k-mer window and emits canonical words.
//
// req channel: one character per transfer in req_tdata, restart flag in
// req_tuser. rsp channel: one result per accepted character, packed as
// canonical word, forward word, window-full flag and repetitive flag.
// csr port: csr_wr_en writes the window length k (1..21, 0 acts as 1,
// larger values act as 21); write it only while no transfer is in flight.
// A character passes through a two-entry queue, the word update stage and the
// result register, in that order. Throughput: one character per cycle while
// rsp_tready is high. When rsp_tready is low the result register holds, the
// update stage holds behind it and the queue fills up to its two entries
// before req_tready falls. Reset clears both words, the fill count, the queue
// and the valid flags of the update stage and the result register, and sets
// k to 15.
// ----------------------------------------------------------------------------
module rolling_canonical_kmer_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rcke_pkg::SYMBOL_W-1:0]   req_tdata,   // [7:0] symbol
   input  logic [0:0]                      req_tuser,   // [0] restart
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [63:0] canonical_code, [127:64] forward_code, [128] window_full,
   // [129] repetitive, [135:130] zero
   output logic [rcke_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [rcke_pkg::FILL_W-1:0]     csr_wr_data  // [4:0] window_length
);
   import rcke_pkg::*;

   logic [FILL_W-1:0] wlen_ff, wlen_in;
   logic [FILL_W-1:0] k;
   logic              q_valid;
   logic              q_pop;
   item_type          q_item;

   assign wlen_in = csr_wr_en ? csr_wr_data : wlen_ff;
   assign k       = eff_k(wlen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= K_RESET;
      end else begin
         wlen_ff <= wlen_in;
      end
   end

   rcke_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   rcke_back u_back (
      .clock      (clock),
      .reset      (reset),
      .k          (k),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/rcke_front.sv =====
// ----------------------------------------------------------------------------
// rcke_front
// Accepts characters, maps them to base and complement codes and queues them.
// ----------------------------------------------------------------------------
module rcke_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rcke_pkg::SYMBOL_W-1:0] req_tdata,   // [7:0] symbol
   input  logic [0:0]                    req_tuser,   // [0] restart
   output logic                          q_valid,
   output rcke_pkg::item_type            q_item,
   input  logic                          q_pop
);
   import rcke_pkg::*;

   localparam int DEPTH = 2;

   item_type   slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   assign req_tready = (count_ff != 2'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.fcode   = base_code(req_tdata);
      new_item.rcode   = comp_code(new_item.fcode);
      new_item.restart = req_tuser[0];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hdl/rcke_back.sv =====
// ----------------------------------------------------------------------------
// rcke_back
// Rolls the forward and reverse words, then picks the canonical word.
// ----------------------------------------------------------------------------
module rcke_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rcke_pkg::FILL_W-1:0]     k,
   input  logic                            q_valid,
   input  rcke_pkg::item_type              q_item,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rcke_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rcke_pkg::*;

   logic [WORD_W-1:0]     fwd_ff, fwd_in;
   logic [WORD_W-1:0]     rev_ff, rev_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_full_ff, s1_full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  out_en;
   logic                  s1_ready;
   logic [WORD_W-1:0]     f0, r0, f1, r1, f2, r2;
   logic [FILL_W-1:0]     n0, n1, n2;
   logic                  rep_f, rep_r;
   logic [WORD_W-1:0]     canon;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || out_en;
   assign q_pop      = q_valid && s1_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      f0 = q_item.restart ? '0 : fwd_ff;
      r0 = q_item.restart ? '0 : rev_ff;
      n0 = q_item.restart ? '0 : fill_ff;
      f1 = f0;
      r1 = r0;
      n1 = n0;
      // drop oldest base and move the reverse terminator down
      if (n0 >= k) begin
         n1 = n0 - 5'd1;
         f1 = f0 >> CODE_W;
         r1 = put_field(put_field(r0, n0, CODE_N), n1, CODE_TERM);
      end
      n2 = n1 + 5'd1;
      f2 = put_field(put_field(f1, n1, q_item.fcode), n2, CODE_TERM);
      r2 = put_field((r1 << CODE_W) | WORD_W'(q_item.rcode), n2, CODE_TERM);

      fwd_in      = fwd_ff;
      rev_in      = rev_ff;
      fill_in     = fill_ff;
      s1_full_in  = s1_full_ff;
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         fwd_in     = f2;
         rev_in     = r2;
         fill_in    = n2;
         s1_full_in = (n2 == k);
      end
      if (s1_ready) begin
         s1_valid_in = q_valid;
      end

      rep_f = is_repetitive(fwd_ff, k);
      rep_r = is_repetitive(rev_ff, k);
      canon = (rep_f && rep_r) ? '1 : ((fwd_ff <= rev_ff) ? fwd_ff : rev_ff);

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_en) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = {6'd0, rep_f, s1_full_ff, fwd_ff, canon};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= '0;
         rev_ff       <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         rev_ff       <= rev_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_full_ff  <= s1_full_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/rcke_checker.sv =====
// ----------------------------------------------------------------------------
// rcke_checker
// Port-level checks of the rolling canonical k-mer encoder.
// ----------------------------------------------------------------------------
module rcke_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [rcke_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rcke_pkg::*;

   logic [WORD_W-1:0] canon;
   logic [WORD_W-1:0] fwd;
   logic              rep;

   assign canon = rsp_tdata[WORD_W-1:0];
   assign fwd   = rsp_tdata[2*WORD_W-1:WORD_W];
   assign rep   = rsp_tdata[2*WORD_W+1];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_canon_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (canon <= fwd) || (&canon))
      else $error("canonical word above forward word");

   a_ones_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (&canon) |-> rep)
      else $error("all-ones canonical word without repetitive forward word");

   a_fwd_term: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fwd != '0))
      else $error("forward word without terminator");

endmodule

bind rolling_canonical_kmer_encoder rcke_checker u_rcke_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rolling canonical k-mer encoder. Characters are
// streamed in, and each accepted one is run through a bit-true software
// version of the window update (forward and reverse-complement words, fill
// count, repeat scan, canonical choice). The expected results are queued and
// every rsp transfer is checked field by field against the oldest one.
// Directed characters come first, then random reads at several window lengths
// under changing idle and backpressure patterns.
// ----------------------------------------------------------------------------
module tb;
   import rcke_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [WORD_W-1:0] canonical;
      logic [WORD_W-1:0] forward;
      logic              full;
      logic              repetitive;
   } kmer_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [SYMBOL_W-1:0]   req_tdata   = '0;
   logic [0:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [FILL_W-1:0]     csr_wr_data = '0;

   kmer_result_type    kmer_q[$];
   int                 error_count   = 0;
   int                 idle_cycles   = 0;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;

   logic [FILL_W-1:0]  window_cfg;
   logic [WORD_W-1:0]  fwd_word;
   logic [WORD_W-1:0]  rev_word;
   int                 fill;

   rolling_canonical_kmer_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [CODE_W-1:0] symbol_to_base(input logic [SYMBOL_W-1:0] s);
      case (s)
         CHAR_UA, CHAR_LA: return CODE_A;
         CHAR_UC, CHAR_LC: return CODE_C;
         CHAR_UG, CHAR_LG: return CODE_G;
         CHAR_UT, CHAR_LT: return CODE_T;
         CHAR_DOLLAR:      return CODE_TERM;
         default:          return CODE_N;
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] symbol_to_complement(input logic [SYMBOL_W-1:0] s);
      case (s)
         CHAR_UA, CHAR_LA: return CODE_T;
         CHAR_UC, CHAR_LC: return CODE_G;
         CHAR_UG, CHAR_LG: return CODE_C;
         CHAR_UT, CHAR_LT: return CODE_A;
         CHAR_DOLLAR:      return CODE_TERM;
         default:          return CODE_N;
      endcase
   endfunction

   function automatic int window_k(input logic [FILL_W-1:0] cfg);
      int k;
      k = cfg;
      if (k < 1) k = 1;
      if (k > MAX_WINDOW) k = MAX_WINDOW;
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] write_code(input logic [WORD_W-1:0] w,
                                                    input int pos,
                                                    input logic [CODE_W-1:0] code);
      int                sh;
      logic [WORD_W-1:0] m;
      sh = (pos % FIELDS) * CODE_W;
      m  = 64'h7 << sh;
      return (w & ~m) | ({61'b0, code} << sh);
   endfunction

   function automatic logic has_two_repeats(input logic [WORD_W-1:0] w, input int k);
      int                pairs;
      logic [CODE_W-1:0] c;
      logic [CODE_W-1:0] prev;
      pairs = 0;
      prev  = '0;
      for (int i = 0; i <= k && i <= MAX_WINDOW; i++) begin
         c = CODE_W'(w >> (i * CODE_W));
         if (i > 0 && c == prev) begin
            pairs++;
            if (pairs >= 2) return 1'b1;
         end
         prev = c;
         if (c == CODE_TERM) break;
      end
      return 1'b0;
   endfunction

   task automatic predict_kmer(input logic [SYMBOL_W-1:0] sym, input logic restart);
      int              k;
      logic            rep_f;
      logic            rep_r;
      kmer_result_type res;
      k = window_k(window_cfg);
      if (restart) begin
         fwd_word = '0;
         rev_word = '0;
         fill     = 0;
      end
      if (fill > MAX_WINDOW) fill = MAX_WINDOW;
      // drop oldest base, re-terminate reverse word one field lower
      if (fill >= k) begin
         rev_word = write_code(rev_word, fill, CODE_N);
         fill--;
         fwd_word = fwd_word >> CODE_W;
         rev_word = write_code(rev_word, fill, CODE_TERM);
      end
      fwd_word = write_code(fwd_word, fill, symbol_to_base(sym));
      rev_word = (rev_word << CODE_W) | {61'b0, symbol_to_complement(sym)};
      fill++;
      fwd_word = write_code(fwd_word, fill, CODE_TERM);
      rev_word = write_code(rev_word, fill, CODE_TERM);
      rep_f = has_two_repeats(fwd_word, k);
      rep_r = has_two_repeats(rev_word, k);
      res.canonical  = (rep_f && rep_r) ? '1 :
                       ((fwd_word <= rev_word) ? fwd_word : rev_word);
      res.forward    = fwd_word;
      res.full       = (fill == k);
      res.repetitive = rep_f;
      kmer_q = {kmer_q, res};
   endtask

   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_kmer(sym, restart);
   endtask

   task automatic write_window_length(input logic [FILL_W-1:0] value);
      req_tvalid <= 1'b0;
      while (kmer_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      window_cfg = value;
   endtask

   function automatic logic [SYMBOL_W-1:0] pick_symbol(input logic [SYMBOL_W-1:0] prev);
      logic [SYMBOL_W-1:0] bases [8];
      int                  r;
      bases = '{CHAR_UA, CHAR_UC, CHAR_UG, CHAR_UT, CHAR_LA, CHAR_LC, CHAR_LG, CHAR_LT};
      r = $urandom_range(99);
      if (r < 25) return prev;
      if (r < 85) return bases[$urandom_range(7)];
      if (r < 95) return SYMBOL_W'($urandom_range(255));
      return CHAR_DOLLAR;
   endfunction

   task automatic test_symbol_map();
      send_symbol(CHAR_UA, 1'b1);
      send_symbol(CHAR_LA, 1'b0);
      send_symbol(CHAR_UC, 1'b0);
      send_symbol(CHAR_LC, 1'b0);
      send_symbol(CHAR_UG, 1'b0);
      send_symbol(CHAR_LG, 1'b0);
      send_symbol(CHAR_UT, 1'b0);
      send_symbol(CHAR_LT, 1'b0);
      send_symbol(CHAR_DOLLAR, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b1);
   endtask

   // long reads at k = 21 reach the top terminator field; lowering k without
   // a restart leaves the fill count above the window
   task automatic test_window_settings();
      logic [FILL_W-1:0]   settings [12];
      logic [SYMBOL_W-1:0] sym;
      int                  mode;
      settings = '{5'd0, 5'd1, 5'd21, 5'd31, 5'd7, 5'd22,
                   5'd21, 5'd3, 5'd15, 5'd21, 5'd2, FILL_W'($urandom_range(31))};
      sym = CHAR_UA;
      for (int p = 0; p < 12; p++) begin
         write_window_length(settings[p]);
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 64 : (mode == 3) ? 9 : 0;
         rsp_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 9 : 0;
         for (int i = 0; i < 162; i++) begin
            sym = pick_symbol(sym);
            send_symbol(sym, (i == 0 && p % 3 == 0) || ($urandom_range(99) < 2));
         end
      end
      req_tvalid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      kmer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (kmer_q.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = kmer_q.pop_front();
            if (rsp_tdata[63:0] !== want.canonical) begin
               $error("canonical_code: expected %h, got %h", want.canonical, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[127:64] !== want.forward) begin
               $error("forward_code: expected %h, got %h", want.forward, rsp_tdata[127:64]);
               error_count++;
            end
            if (rsp_tdata[128] !== want.full) begin
               $error("window_full: expected %b, got %b", want.full, rsp_tdata[128]);
               error_count++;
            end
            if (rsp_tdata[129] !== want.repetitive) begin
               $error("repetitive: expected %b, got %b", want.repetitive, rsp_tdata[129]);
               error_count++;
            end
            if (rsp_tdata[135:130] !== 6'd0) begin
               $error("padding: expected %h, got %h", 6'd0, rsp_tdata[135:130]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      window_cfg = K_RESET;
      fwd_word   = '0;
      rev_word   = '0;
      fill       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_symbol_map();
      test_window_settings();
      while (kmer_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
